@@ sv/tsu_pkg.sv @@
// ----------------------------------------------------------------------------
// tsu_pkg
// Types and constants shared by the tab-stop unit modules.
// ----------------------------------------------------------------------------
package tsu_pkg;

  localparam int unsigned COL_W = 8;   // column, cursor and count width
  localparam int unsigned ROW_W = 8;   // stop bits held in one memory row

  // Request kinds carried in in_tuser
  localparam logic [1:0] REQ_TAB   = 2'd0;
  localparam logic [1:0] REQ_EDIT  = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;
  localparam logic [1:0] REQ_DFLT  = 2'd3;

  // Row contents after reset or a restore: stop at the first column of a row
  localparam logic [ROW_W-1:0] DFLT_ROW = 8'h01;
  localparam logic [ROW_W-1:0] ZERO_ROW = 8'h00;

  localparam logic [COL_W-1:0] LW_RESET = 8'd80;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WRITE,
    S_TAB_START,
    S_SCAN,
    S_RESULT
  } tsu_state_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic clr_en;
    logic clr_dflt;
  } tsu_ram_op_t;

endpackage

@@ sv/tsu_stop_ram.sv @@
// ----------------------------------------------------------------------------
// tsu_stop_ram
// Row memory of tab-stop bits, eight columns per row, with per-row valid
// bits and a fill pattern, so that clear-all and restore touch no memory row.
// ----------------------------------------------------------------------------
module tsu_stop_ram #(
  parameter int unsigned ROWS = 32,
  parameter int unsigned AW   = 5
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  tsu_pkg::tsu_ram_op_t        op,
  input  logic [AW-1:0]               addr,
  input  logic [tsu_pkg::ROW_W-1:0]   wdata,
  output logic [tsu_pkg::ROW_W-1:0]   rdata
);

  logic [tsu_pkg::ROW_W-1:0] mem [ROWS];
  logic [ROWS-1:0]           row_vld_r;
  logic                      fill_dflt_r;
  logic [tsu_pkg::ROW_W-1:0] rd_data_r;
  logic                      rd_vld_r;

  always_ff @(posedge clk) begin
    if (op.wr_en) begin
      mem[addr] <= wdata;
    end
    if (op.rd_en) begin
      rd_data_r <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r   <= '0;
      fill_dflt_r <= 1'b1;
      rd_vld_r    <= 1'b0;
    end else begin
      if (op.clr_en) begin
        row_vld_r   <= '0;
        fill_dflt_r <= op.clr_dflt;
      end else if (op.wr_en) begin
        row_vld_r[addr] <= 1'b1;
      end
      if (op.rd_en) begin
        rd_vld_r <= row_vld_r[addr];
      end
    end
  end

  // unwritten rows read as the current fill pattern
  assign rdata = rd_vld_r ? rd_data_r
                          : (fill_dflt_r ? tsu_pkg::DFLT_ROW : tsu_pkg::ZERO_ROW);

endmodule

@@ sv/tsu_seq.sv @@
// ----------------------------------------------------------------------------
// tsu_seq
// Request sequencer: table edits by read-modify-write, tab forward by a
// row-at-a-time scan of the stop memory, one repeat after another.
// ----------------------------------------------------------------------------
module tsu_seq #(
  parameter int unsigned MAX_COLUMNS = 256,
  parameter int unsigned AW          = 5
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [tsu_pkg::COL_W-1:0]   line_width,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  in_req_type,
  input  logic [tsu_pkg::COL_W-1:0]   in_column,
  input  logic                        in_set_value,
  input  logic [tsu_pkg::COL_W-1:0]   in_cursor_x,
  input  logic [tsu_pkg::COL_W-1:0]   in_repeat_count,
  output tsu_pkg::tsu_ram_op_t        ram_op,
  output logic [AW-1:0]               ram_addr,
  output logic [tsu_pkg::ROW_W-1:0]   ram_wdata,
  input  logic [tsu_pkg::ROW_W-1:0]   ram_rdata,
  output logic                        res_valid,
  input  logic                        res_ready,
  output logic [tsu_pkg::COL_W-1:0]   res_col
);

  localparam int unsigned LIM_INT = (MAX_COLUMNS - 1 > 255) ? 255 : MAX_COLUMNS - 1;
  localparam logic [tsu_pkg::COL_W-1:0] LIM = 8'(LIM_INT);

  tsu_pkg::tsu_state_t state_r, state_nxt;
  logic [1:0]                req_r, req_nxt;
  logic [tsu_pkg::COL_W-1:0] col_r, col_nxt;
  logic                      val_r, val_nxt;
  logic [tsu_pkg::COL_W-1:0] x_r, x_nxt;
  logic [tsu_pkg::COL_W-1:0] rep_r, rep_nxt;
  logic [4:0]                row_r, row_nxt;

  logic                      accept;
  logic                      col_in_table;
  logic [tsu_pkg::COL_W-1:0] bnd;
  logic [tsu_pkg::COL_W-1:0] step_x;
  logic [7:0]                hit_mask;
  logic [2:0]                hit_idx;
  logic                      hit;
  logic                      row_last;

  assign accept       = in_valid && in_ready;
  assign col_in_table = 32'(in_column) < MAX_COLUMNS;
  assign bnd          = (line_width < LIM) ? line_width : LIM;
  assign step_x       = x_r + 8'd1;
  assign row_last     = ({1'b0, row_r, 3'b000} + 9'd8) >= {1'b0, bnd};

  always_comb begin
    logic [tsu_pkg::COL_W-1:0] c;
    hit_mask = '0;
    hit_idx  = '0;
    for (int i = 0; i < 8; i++) begin
      c           = {row_r, 3'(i)};
      hit_mask[i] = ram_rdata[i] && (c > x_r) && (c < bnd);
    end
    for (int i = 7; i >= 0; i--) begin
      if (hit_mask[i]) begin
        hit_idx = 3'(i);
      end
    end
    hit = |hit_mask;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    req_nxt   = req_r;
    col_nxt   = col_r;
    val_nxt   = val_r;
    x_nxt     = x_r;
    rep_nxt   = rep_r;
    row_nxt   = row_r;
    case (state_r)
      tsu_pkg::S_IDLE: begin
        if (accept) begin
          req_nxt   = in_req_type;
          col_nxt   = in_column;
          val_nxt   = in_set_value;
          x_nxt     = in_cursor_x;
          rep_nxt   = in_repeat_count;
          state_nxt = tsu_pkg::S_RESULT;
          if (in_req_type == tsu_pkg::REQ_TAB && in_repeat_count != '0) begin
            x_nxt     = (in_cursor_x > LIM) ? LIM : in_cursor_x;
            state_nxt = tsu_pkg::S_TAB_START;
          end else if (in_req_type == tsu_pkg::REQ_EDIT && col_in_table) begin
            state_nxt = tsu_pkg::S_WRITE;
          end
        end
      end
      tsu_pkg::S_WRITE: begin
        state_nxt = tsu_pkg::S_RESULT;
      end
      tsu_pkg::S_TAB_START: begin
        if (x_r >= LIM || step_x >= bnd) begin
          x_nxt     = (x_r >= LIM) ? LIM : step_x;
          rep_nxt   = rep_r - 8'd1;
          state_nxt = (rep_r == 8'd1) ? tsu_pkg::S_RESULT : tsu_pkg::S_TAB_START;
        end else begin
          row_nxt   = step_x[7:3];
          state_nxt = tsu_pkg::S_SCAN;
        end
      end
      tsu_pkg::S_SCAN: begin
        if (hit || row_last) begin
          x_nxt     = hit ? {row_r, hit_idx} : bnd;
          rep_nxt   = rep_r - 8'd1;
          state_nxt = (rep_r == 8'd1) ? tsu_pkg::S_RESULT : tsu_pkg::S_TAB_START;
        end else begin
          row_nxt = row_r + 5'd1;
        end
      end
      tsu_pkg::S_RESULT: begin
        if (res_ready) begin
          state_nxt = tsu_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = tsu_pkg::S_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    ram_op    = '0;
    ram_addr  = '0;
    ram_wdata = ram_rdata;
    in_ready  = 1'b0;
    res_valid = 1'b0;
    case (state_r)
      tsu_pkg::S_IDLE: begin
        in_ready = 1'b1;
        ram_addr = AW'(in_column[7:3]);
        if (in_valid) begin
          ram_op.rd_en    = (in_req_type == tsu_pkg::REQ_EDIT) && col_in_table;
          ram_op.clr_en   = (in_req_type == tsu_pkg::REQ_CLEAR) ||
                            (in_req_type == tsu_pkg::REQ_DFLT);
          ram_op.clr_dflt = (in_req_type == tsu_pkg::REQ_DFLT);
        end
      end
      tsu_pkg::S_WRITE: begin
        ram_addr              = AW'(col_r[7:3]);
        ram_op.wr_en          = 1'b1;
        ram_wdata[col_r[2:0]] = val_r;
      end
      tsu_pkg::S_TAB_START: begin
        ram_addr     = AW'(step_x[7:3]);
        ram_op.rd_en = (x_r < LIM) && (step_x < bnd);
      end
      tsu_pkg::S_SCAN: begin
        ram_addr     = AW'(row_r + 5'd1);
        ram_op.rd_en = !hit && !row_last;
      end
      tsu_pkg::S_RESULT: begin
        res_valid = 1'b1;
      end
      default: begin
        ram_op = '0;
      end
    endcase
  end

  assign res_col = x_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tsu_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r <= req_nxt;
    col_r <= col_nxt;
    val_r <= val_nxt;
    x_r   <= x_nxt;
    rep_r <= rep_nxt;
    row_r <= row_nxt;
  end

  a_scan_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tsu_pkg::S_SCAN) |-> $past(ram_op.rd_en))
    else $error("scan row without a memory read");

  a_write_only_edit: assert property (@(posedge clk) disable iff (!rst_n)
    ram_op.wr_en |-> (state_r == tsu_pkg::S_WRITE) && (req_r == tsu_pkg::REQ_EDIT))
    else $error("stop memory written outside an edit");

  a_scan_in_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tsu_pkg::S_SCAN) |-> (x_r < bnd) && (rep_r != '0))
    else $error("scan started past the bound");

  a_tab_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tsu_pkg::S_TAB_START) |-> (x_r <= LIM))
    else $error("cursor beyond right limit during tab");

endmodule

@@ sv/terminal_tab_stop_unit.sv @@
// ----------------------------------------------------------------------------
// terminal_tab_stop_unit
// Tab-stop table of a character terminal with tab-forward search.
//
// Input channel (in_*): one request per transaction; in_tuser gives the
// request kind (tab forward, set/clear one stop, clear all, restore).
// Output channel (out_*): exactly one result per request, in order; the new
// cursor column for a tab, cursor_x echoed otherwise.
// cfg_we/cfg_wdata write the line width; write only while idle.
// Edits read the row, write it back, then register the result; clear, restore
// and a zero-count tab register it directly. A tab takes a start step per
// repeat and a scan step per 8-column row scanned, the single-port stop
// memory being read one row per cycle. One request is in work at a time.
// Reset loads the line width 80 and the default stops at every eighth
// column at once; requests are taken from the first cycle after reset.
// A stalled output holds its result in the output register; one further
// request is processed meanwhile, then in_tready stays low.
// ----------------------------------------------------------------------------
module terminal_tab_stop_unit #(
  parameter int unsigned MAX_COLUMNS = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,    // line_width
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,     // column[7:0], set_value[8], cursor_x[16:9],
                                    // repeat_count[24:17], zero[31:25]
  input  logic [1:0]  in_tuser,     // req_type[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata     // new_column[7:0]
);

  localparam int unsigned ROWS = (MAX_COLUMNS + tsu_pkg::ROW_W - 1) / tsu_pkg::ROW_W;
  localparam int unsigned AW   = (ROWS > 1) ? $clog2(ROWS) : 1;

  logic [tsu_pkg::COL_W-1:0] lw_r;
  logic                      out_valid_r;
  logic [tsu_pkg::COL_W-1:0] out_col_r;

  tsu_pkg::tsu_ram_op_t      ram_op;
  logic [AW-1:0]             ram_addr;
  logic [tsu_pkg::ROW_W-1:0] ram_wdata;
  logic [tsu_pkg::ROW_W-1:0] ram_rdata;
  logic                      res_valid;
  logic                      res_ready;
  logic [tsu_pkg::COL_W-1:0] res_col;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lw_r <= tsu_pkg::LW_RESET;
    end else if (cfg_we) begin
      lw_r <= cfg_wdata;
    end
  end

  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_col_r <= res_col;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_col_r;

  tsu_seq #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .AW          (AW)
  ) u_seq (
    .clk             (clk),
    .rst_n           (rst_n),
    .line_width      (lw_r),
    .in_valid        (in_tvalid),
    .in_ready        (in_tready),
    .in_req_type     (in_tuser),
    .in_column       (in_tdata[7:0]),
    .in_set_value    (in_tdata[8]),
    .in_cursor_x     (in_tdata[16:9]),
    .in_repeat_count (in_tdata[24:17]),
    .ram_op          (ram_op),
    .ram_addr        (ram_addr),
    .ram_wdata       (ram_wdata),
    .ram_rdata       (ram_rdata),
    .res_valid       (res_valid),
    .res_ready       (res_ready),
    .res_col         (res_col)
  );

  tsu_stop_ram #(
    .ROWS (ROWS),
    .AW   (AW)
  ) u_ram (
    .clk   (clk),
    .rst_n (rst_n),
    .op    (ram_op),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

endmodule

@@ test/terminal_tab_stop_unit_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// terminal_tab_stop_unit_tb
// Self-checking bench for the tab-stop unit. A tracker class keeps its own
// stop table and line width, works out the cursor column for every accepted
// request and compares the results in order. Directed requests come first,
// then random phases at several line widths (0, 1, 80, 255 among them) with
// varying source gaps, sink stalls and one long sink hold-off.
// ----------------------------------------------------------------------------
module terminal_tab_stop_unit_tb;

  localparam int unsigned MAX_COLS    = 256;
  localparam int          IDLE_LIMIT  = 5000;
  localparam int          LONG_HOLD   = 300;
  localparam int          N_PHASES    = 8;
  localparam int          PHASE_ITEMS = 155;

  typedef struct {
    logic [1:0] kind;
    logic [7:0] col;
    logic       set;
    logic [7:0] cur;
    logic [7:0] rep;
  } tab_req_t;

  class tab_stop_tracker;
    bit         stops[MAX_COLS];
    logic [7:0] width;
    logic [7:0] expected_columns[$];
    int         kind_count[4];
    int         checked;
    int         failures;

    function new();
      width = tsu_pkg::LW_RESET;
      load_defaults();
    endfunction

    function void load_defaults();
      for (int c = 0; c < MAX_COLS; c++) stops[c] = (c % 8) == 0;
    endfunction

    function void set_width(logic [7:0] w);
      width = w;
    endfunction

    function int unsigned right_edge();
      return (MAX_COLS - 1 > 255) ? 255 : MAX_COLS - 1;
    endfunction

    function int unsigned advance_to_stop(int unsigned x);
      int unsigned lim;
      lim = right_edge();
      if (x >= lim) return lim;
      x++;
      while (x < lim && x < width && !stops[x]) x++;
      return x;
    endfunction

    function void note_request(tab_req_t r);
      int unsigned x;
      x = 32'(r.cur);
      kind_count[r.kind]++;
      case (r.kind)
        tsu_pkg::REQ_TAB: begin
          if (r.rep != 0) begin
            if (x > right_edge()) x = right_edge();
            for (int k = 0; k < r.rep; k++) x = advance_to_stop(x);
          end
        end
        tsu_pkg::REQ_EDIT: begin
          if (r.col < MAX_COLS) stops[r.col] = r.set;
        end
        tsu_pkg::REQ_CLEAR: begin
          for (int c = 0; c < MAX_COLS; c++) stops[c] = 1'b0;
        end
        default: begin
          load_defaults();
        end
      endcase
      expected_columns.push_back(x[7:0]);
    endfunction

    function void check_column(logic [7:0] got);
      logic [7:0] want;
      if (expected_columns.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("%0t: unexpected result transaction, column %0d", $time, got);
        return;
      end
      want = expected_columns.pop_front();
      checked++;
      if (got !== want) begin
        failures++;
        if (failures <= 10)
          $display("%0t: new_column mismatch, expected %0d got %0d", $time, want, got);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [7:0]  cfg_wdata = 8'd0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = 32'd0;
  logic [1:0]  in_tuser = tsu_pkg::REQ_TAB;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;

  tab_stop_tracker sb = new();

  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int hold_req_n = 0;
  int hold_seen_n = 0;
  int hold_cnt = 0;
  int quiet_cycles = 0;
  int width_writes = 0;

  int phase_width[N_PHASES] = '{80, 255, 0, 1, -1, 255, 8, 80};
  int phase_mode[N_PHASES]  = '{0, 1, 2, 3, 0, 2, 1, 3};

  terminal_tab_stop_unit #(.MAX_COLUMNS(MAX_COLS)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result sink: check, then choose next tready (long hold-off has priority)
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_column(out_tdata);
    if (hold_seen_n != hold_req_n) begin
      hold_seen_n = hold_req_n;
      hold_cnt = LONG_HOLD;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic tab_req_t mk(logic [1:0] kind, logic [7:0] col, logic set,
                                  logic [7:0] cur, logic [7:0] rep);
    tab_req_t r;
    r.kind = kind;
    r.col  = col;
    r.set  = set;
    r.cur  = cur;
    r.rep  = rep;
    return r;
  endfunction

  function automatic tab_req_t random_req(logic [7:0] lw);
    tab_req_t r;
    int pick;
    pick   = $urandom_range(99);
    r.col  = 8'($urandom_range(255));
    r.set  = 1'($urandom_range(1));
    r.cur  = 8'($urandom_range(255));
    r.rep  = 8'($urandom_range(255));
    if (pick < 62) begin
      r.kind = tsu_pkg::REQ_TAB;
      if ($urandom_range(99) < 75) r.cur = 8'($urandom_range(lw));
      pick = $urandom_range(99);
      if (pick < 70) r.rep = 8'($urandom_range(3));
      else if (pick < 90) r.rep = 8'($urandom_range(16, 4));
    end else if (pick < 90) begin
      r.kind = tsu_pkg::REQ_EDIT;
      if ($urandom_range(99) < 70) r.col = 8'($urandom_range(lw));
    end else if (pick < 95) begin
      r.kind = tsu_pkg::REQ_DFLT;
    end else begin
      r.kind = tsu_pkg::REQ_CLEAR;
    end
    return r;
  endfunction

  task automatic offer(input tab_req_t r);
    in_tvalid <= 1'b1;
    in_tuser  <= r.kind;
    in_tdata  <= {7'd0, r.rep, r.cur, r.set, r.col};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_request(r);
  endtask

  task automatic send(input tab_req_t r);
    if (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
    offer(r);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.expected_columns.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_width(input logic [7:0] w);
    cfg_we    <= 1'b1;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.set_width(w);
    width_writes++;
  endtask

  task automatic directed_requests();
    send(mk(tsu_pkg::REQ_TAB, 8'd0, 1'b0, 8'd37, 8'd0));
    send(mk(tsu_pkg::REQ_TAB, 8'd0, 1'b0, 8'd0, 8'd1));
    send(mk(tsu_pkg::REQ_TAB, 8'd0, 1'b0, 8'd79, 8'd1));
    send(mk(tsu_pkg::REQ_TAB, 8'd0, 1'b0, 8'd80, 8'd3));
    send(mk(tsu_pkg::REQ_TAB, 8'hFF, 1'b1, 8'd255, 8'd1));
    send(mk(tsu_pkg::REQ_TAB, 8'd0, 1'b0, 8'd254, 8'd255));
    send(mk(tsu_pkg::REQ_TAB, 8'd0, 1'b0, 8'd0, 8'd255));
    send(mk(tsu_pkg::REQ_EDIT, 8'd3, 1'b1, 8'hAA, 8'h55));
    send(mk(tsu_pkg::REQ_TAB, 8'd0, 1'b0, 8'd0, 8'd2));
    send(mk(tsu_pkg::REQ_EDIT, 8'd8, 1'b0, 8'd0, 8'd0));
    send(mk(tsu_pkg::REQ_TAB, 8'd0, 1'b0, 8'd3, 8'd1));
    send(mk(tsu_pkg::REQ_EDIT, 8'd255, 1'b1, 8'hFF, 8'hFF));
    send(mk(tsu_pkg::REQ_EDIT, 8'd0, 1'b0, 8'd0, 8'd0));
    send(mk(tsu_pkg::REQ_TAB, 8'd0, 1'b0, 8'd250, 8'd1));
    send(mk(tsu_pkg::REQ_CLEAR, 8'hFF, 1'b1, 8'h55, 8'hFF));
    send(mk(tsu_pkg::REQ_TAB, 8'd0, 1'b0, 8'd0, 8'd1));
    send(mk(tsu_pkg::REQ_TAB, 8'd0, 1'b0, 8'd5, 8'd255));
    send(mk(tsu_pkg::REQ_EDIT, 8'd40, 1'b1, 8'd0, 8'd0));
    send(mk(tsu_pkg::REQ_TAB, 8'd0, 1'b0, 8'd39, 8'd1));
    send(mk(tsu_pkg::REQ_TAB, 8'd0, 1'b0, 8'd40, 8'd2));
    send(mk(tsu_pkg::REQ_DFLT, 8'hA5, 1'b0, 8'hC3, 8'h81));
    send(mk(tsu_pkg::REQ_TAB, 8'd0, 1'b0, 8'd7, 8'd1));
    send(mk(tsu_pkg::REQ_TAB, 8'd0, 1'b0, 8'd72, 8'd255));
  endtask

  initial begin
    logic [7:0] lw;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int p = 0; p < N_PHASES; p++) begin
      case (phase_mode[p])
        1:       begin tx_idle_pct = 57; rx_stall_pct = 0;  end
        2:       begin tx_idle_pct = 0;  rx_stall_pct = 57; end
        3:       begin tx_idle_pct = 25; rx_stall_pct = 25; end
        default: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
      endcase
      if (p == 0) begin
        lw = tsu_pkg::LW_RESET;
        directed_requests();
      end else begin
        lw = (phase_width[p] < 0) ? 8'($urandom_range(254, 2)) : 8'(phase_width[p]);
        write_width(lw);
      end
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (p == 4 && i == 20) hold_req_n++;
        send(random_req(lw));
      end
      drain();
    end

    repeat (20) @(posedge clk);
    $display("Covered %0d tab, %0d edit, %0d clear-all and %0d restore requests,",
             sb.kind_count[tsu_pkg::REQ_TAB], sb.kind_count[tsu_pkg::REQ_EDIT],
             sb.kind_count[tsu_pkg::REQ_CLEAR], sb.kind_count[tsu_pkg::REQ_DFLT]);
    $display("%0d results checked over %0d line-width writes, %0d failures, %0d left over",
             sb.checked, width_writes, sb.failures, sb.expected_columns.size());
    if (sb.failures == 0 && sb.expected_columns.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/tsu_pkg.sv
sv/tsu_stop_ram.sv
sv/tsu_seq.sv
sv/terminal_tab_stop_unit.sv
test/terminal_tab_stop_unit_tb.sv
